FILE: rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared constants and types for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   localparam int TICK_COUNT_WIDTH = 10;
   localparam int PHASE_TICKS_W    = 10;
   localparam int TICK_CMP_W       = (TICK_COUNT_WIDTH + 1 > PHASE_TICKS_W) ?
                                     (TICK_COUNT_WIDTH + 1) : PHASE_TICKS_W;

   localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = PHASE_TICKS_W'(10);

   localparam logic [2:0] CMD_START    = 3'd0;
   localparam logic [2:0] CMD_STOP     = 3'd1;
   localparam logic [2:0] CMD_WRITE    = 3'd2;
   localparam logic [2:0] CMD_READ     = 3'd3;
   localparam logic [2:0] CMD_SEND_ACK = 3'd4;
   localparam logic [2:0] CMD_RECV_ACK = 3'd5;

   typedef enum logic [2:0] {
      OP_SCL0,
      OP_SCL1,
      OP_SDA0,
      OP_SDA1,
      OP_SDA_TXMSB,
      OP_SDA_TXLSB,
      OP_SAMPLE_BIT,
      OP_SAMPLE_ACK
   } op_type;

   typedef struct packed {
      logic       ack_seen;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } i2cms_result_type;

endpackage

FILE: rtl/i2cms_seq.sv
// ----------------------------------------------------------------------------
// i2cms_seq
// Command phase sequencer: holds the line state and advances it one tick per
// step, presenting the result of that tick.
// ----------------------------------------------------------------------------
module i2cms_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                cmd_valid,
   input  logic [2:0]                          mode,
   input  logic [7:0]                          tx_byte,
   input  logic                                sda_in,
   input  logic [i2cms_pkg::PHASE_TICKS_W-1:0] phase_ticks,
   output i2cms_pkg::i2cms_result_type         next_result
);
   import i2cms_pkg::*;

   function automatic logic [4:0] phase_total(input logic [2:0] cmd);
      case (cmd)
         CMD_START:    phase_total = 5'd4;
         CMD_STOP:     phase_total = 5'd3;
         CMD_WRITE:    phase_total = 5'd24;
         CMD_READ:     phase_total = 5'd25;
         CMD_SEND_ACK: phase_total = 5'd3;
         default:      phase_total = 5'd4;
      endcase
   endfunction

   // sub is the position within a three-phase bit slot
   function automatic op_type phase_op(input logic [2:0] cmd, input logic [4:0] p,
                                       input logic [1:0] sub);
      op_type op;
      case (cmd)
         CMD_START: begin
            case (p[1:0])
               2'd0:    op = OP_SDA1;
               2'd1:    op = OP_SCL1;
               2'd2:    op = OP_SDA0;
               default: op = OP_SCL0;
            endcase
         end
         CMD_STOP: begin
            case (p)
               5'd0:    op = OP_SDA0;
               5'd1:    op = OP_SCL1;
               default: op = OP_SDA1;
            endcase
         end
         CMD_WRITE: begin
            case (sub)
               2'd0:    op = OP_SDA_TXMSB;
               2'd1:    op = OP_SCL1;
               default: op = OP_SCL0;
            endcase
         end
         CMD_READ: begin
            if (p == 5'd0) begin
               op = OP_SDA1;
            end else begin
               case (sub)
                  2'd0:    op = OP_SCL1;
                  2'd1:    op = OP_SAMPLE_BIT;
                  default: op = OP_SCL0;
               endcase
            end
         end
         CMD_SEND_ACK: begin
            case (p)
               5'd0:    op = OP_SDA_TXLSB;
               5'd1:    op = OP_SCL1;
               default: op = OP_SCL0;
            endcase
         end
         default: begin
            case (p[1:0])
               2'd0:    op = OP_SDA1;
               2'd1:    op = OP_SCL1;
               2'd2:    op = OP_SAMPLE_ACK;
               default: op = OP_SCL0;
            endcase
         end
      endcase
      return op;
   endfunction

   logic [2:0]                  cmd_ff, cmd_in;
   logic [4:0]                  phase_ff, phase_in;
   logic [1:0]                  sub_ff, sub_in;
   logic [TICK_COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [7:0]                  tx_ff, tx_in;
   logic [7:0]                  rx_ff, rx_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in_lvl;
   logic                        busy_ff, busy_in;
   logic [7:0]                  rx_hold_ff, rx_hold_in;
   logic                        ack_hold_ff, ack_hold_in;
   logic                        done;

   logic                        do_op;
   logic [PHASE_TICKS_W-1:0]    limit;
   logic [TICK_CMP_W-1:0]       tick_sum;
   logic                        start_ok;

   assign limit    = (phase_ticks == '0) ? PHASE_TICKS_W'(1) : phase_ticks;
   assign tick_sum = TICK_CMP_W'(tick_ff) + TICK_CMP_W'(1);
   assign start_ok = cmd_valid && (mode <= CMD_RECV_ACK);

   always_comb begin
      cmd_in      = cmd_ff;
      phase_in    = phase_ff;
      sub_in      = sub_ff;
      tick_in     = tick_ff;
      tx_in       = tx_ff;
      rx_in       = rx_ff;
      scl_in      = scl_ff;
      sda_in_lvl  = sda_ff;
      busy_in     = busy_ff;
      rx_hold_in  = rx_hold_ff;
      ack_hold_in = ack_hold_ff;
      done        = 1'b0;
      do_op       = 1'b0;

      if (busy_ff) begin
         if (tick_sum >= TICK_CMP_W'(limit)) begin
            phase_in = phase_ff + 5'd1;
            tick_in  = '0;
            sub_in   = ((cmd_ff == CMD_READ) && (phase_ff == 5'd0)) ? 2'd0 :
                       ((sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1);
            if (phase_in >= phase_total(cmd_ff)) begin
               busy_in  = 1'b0;
               done     = 1'b1;
               phase_in = '0;
               if (cmd_ff == CMD_READ) begin
                  rx_hold_in = rx_ff;
               end
            end else begin
               do_op = 1'b1;
            end
         end else begin
            tick_in = tick_sum[TICK_COUNT_WIDTH-1:0];
         end
      end else if (start_ok) begin
         cmd_in   = mode;
         phase_in = '0;
         sub_in   = '0;
         tick_in  = '0;
         tx_in    = tx_byte;
         if (mode == CMD_READ) begin
            rx_in = '0;
         end
         busy_in = 1'b1;
         do_op   = 1'b1;
      end

      if (do_op) begin
         case (phase_op(cmd_in, phase_in, sub_in))
            OP_SCL0: scl_in = 1'b0;
            OP_SCL1: scl_in = 1'b1;
            OP_SDA0: sda_in_lvl = 1'b0;
            OP_SDA1: sda_in_lvl = 1'b1;
            OP_SDA_TXMSB: begin
               sda_in_lvl = tx_in[7];
               tx_in      = {tx_in[6:0], 1'b0};
            end
            OP_SDA_TXLSB:  sda_in_lvl = tx_in[0];
            OP_SAMPLE_BIT: rx_in = {rx_in[6:0], sda_in};
            default:       ack_hold_in = sda_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff      <= '0;
         phase_ff    <= '0;
         sub_ff      <= '0;
         tick_ff     <= '0;
         tx_ff       <= '0;
         rx_ff       <= '0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         busy_ff     <= 1'b0;
         rx_hold_ff  <= '0;
         ack_hold_ff <= 1'b1;
      end else if (step) begin
         cmd_ff      <= cmd_in;
         phase_ff    <= phase_in;
         sub_ff      <= sub_in;
         tick_ff     <= tick_in;
         tx_ff       <= tx_in;
         rx_ff       <= rx_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in_lvl;
         busy_ff     <= busy_in;
         rx_hold_ff  <= rx_hold_in;
         ack_hold_ff <= ack_hold_in;
      end
   end

   assign next_result.scl_out  = scl_in;
   assign next_result.sda_out  = sda_in_lvl;
   assign next_result.busy_res = busy_in;
   assign next_result.done_res = done;
   assign next_result.rx_byte  = rx_hold_in;
   assign next_result.ack_seen = ack_hold_in;

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (phase_ff < phase_total(cmd_ff)))
      else $error("phase index past end of command");

   a_idle_counters_clear: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (phase_ff == 5'd0) && (tick_ff == '0))
      else $error("counters not clear while idle");

   a_start_enters_phase0: assert property (@(posedge clock) disable iff (reset)
      (step && !busy_ff && start_ok) |=> busy_ff && (phase_ff == 5'd0) && (tick_ff == '0))
      else $error("command start did not enter phase zero");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (step && done) |=> !busy_ff && $past(busy_ff))
      else $error("done without running command");

endmodule

FILE: rtl/i2c_master_bit_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// I2C master line sequencer with stream request/response channels.
// ----------------------------------------------------------------------------
// Each request transaction is one bus tick and produces exactly one response
// transaction in the next cycle, carrying the SCL/SDA drive levels and status
// after that tick. A request is taken in every clock while the response side
// keeps rsp_tready high; the sequencer state advances only on accepted ticks.
// The user must write phase_ticks through csr_wr_en/csr_wr_data only while no
// command is running; the block itself does not enforce this.
module i2c_master_bit_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // tx_byte, sda_in, zero pad
   input  logic [3:0]                          req_tuser,   // cmd_valid, mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // scl_out, sda_out, busy_res,
                                                            // done_res, rx_byte, ack_seen,
                                                            // zero pad
   input  logic                                csr_wr_en,
   input  logic [i2cms_pkg::PHASE_TICKS_W-1:0] csr_wr_data
);
   import i2cms_pkg::*;

   logic                     accept;
   logic                     rsp_valid_ff, rsp_valid_in;
   i2cms_result_type         rsp_data_ff;
   i2cms_result_type         next_result;
   logic [PHASE_TICKS_W-1:0] phase_ticks_ff;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   i2cms_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .cmd_valid   (req_tuser[0]),
      .mode        (req_tuser[3:1]),
      .tx_byte     (req_tdata[7:0]),
      .sda_in      (req_tdata[8]),
      .phase_ticks (phase_ticks_ff),
      .next_result (next_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= next_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no response");

endmodule
